>>> rtl/core/cst_pkg.sv
// shared types, constants and fixed-point helpers for the cubic spline table evaluator
package cst_pkg;

   localparam int NUM_FUNCS_DEF    = 4;
   localparam int NUM_SEGMENTS_DEF = 256;

   localparam int COEF_W     = 32;
   localparam int OFFSET_W   = 16;
   localparam int FUNC_W     = 2;
   localparam int SEG_W      = 8;
   localparam int SLOT_W     = 2;
   localparam int NUM_SLOTS  = 4;
   localparam int ROUND_BITS = 16;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 64;

   localparam int PROD_W = 56;
   localparam int ACC_W  = 40;

   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2 ** (ROUND_BITS - 1));

   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};

   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W - COEF_W + 1){1'b0}}, {(COEF_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN =
      {{(ACC_W - COEF_W + 1){1'b1}}, {(COEF_W - 1){1'b0}}};

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef struct packed {
      logic [REQ_DATA_W-FUNC_W-SEG_W-SLOT_W-COEF_W-OFFSET_W-1:0] pad;
      logic [OFFSET_W-1:0]                                         offset;
      logic [COEF_W-1:0]                                           coef_value;
      logic [SLOT_W-1:0]                                           coef_slot;
      logic [SEG_W-1:0]                                            segment;
      logic [FUNC_W-1:0]                                           func_index;
   } req_data_type;

   typedef struct packed {
      logic                valid;
      logic                in_range;
      logic                last;
      logic [OFFSET_W-1:0] offset;
   } tag_type;

   typedef logic [NUM_SLOTS-1:0][COEF_W-1:0] coef_set_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] word;
      logic                     clip;
   } sat_type;

   // round to nearest, ties up, of prod / 2^16
   function automatic logic signed [ACC_W-1:0] round_q16(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-1:0] biased;
      biased = prod + RND_HALF;
      return biased[ACC_W+ROUND_BITS-1:ROUND_BITS];
   endfunction

   function automatic sat_type sat_q24(input logic signed [ACC_W-1:0] x);
      sat_type r;
      if (x > SAT_MAX) begin
         r.word = COEF_MAX;
         r.clip = 1'b1;
      end else if (x < SAT_MIN) begin
         r.word = COEF_MIN;
         r.clip = 1'b1;
      end else begin
         r.word = x[COEF_W-1:0];
         r.clip = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/cst_ram.sv
// generic single-write, single-read synchronous ram with registered read
module cst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/cst_coef_store.sv
// coefficient table: item decode, one ram per coefficient slot, read stage register
module cst_coef_store #(
   parameter int NUM_FUNCS    = cst_pkg::NUM_FUNCS_DEF,
   parameter int NUM_SEGMENTS = cst_pkg::NUM_SEGMENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cst_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   input  logic                            adv,
   output cst_pkg::tag_type                rd_tag,
   output cst_pkg::coef_set_type           rd_coefs
);
   import cst_pkg::*;

   localparam int DEPTH  = NUM_FUNCS * NUM_SEGMENTS;
   localparam int ADDR_W = $clog2(DEPTH);

   req_data_type      req_data;
   logic              fire;
   logic              in_range;
   logic [31:0]       lin_addr;
   logic [ADDR_W-1:0] addr;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_in_range_ff;
   logic              s1_last_ff;
   logic [OFFSET_W-1:0] s1_offset_ff;

   assign req_data   = req_data_type'(req_tdata);
   assign req_tready = !s1_valid_ff || adv;
   assign fire       = req_tvalid && req_tready;
   assign in_range   = (32'(req_data.func_index) < NUM_FUNCS) &&
                       (32'(req_data.segment) < NUM_SEGMENTS);
   assign lin_addr   = 32'(req_data.func_index) * 32'(NUM_SEGMENTS) + 32'(req_data.segment);
   assign addr       = lin_addr[ADDR_W-1:0];
   assign s1_valid_in = fire && (op_type'(req_tuser) == OP_EVAL);

   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
      logic we;
      assign we = fire && (op_type'(req_tuser) == OP_LOAD) && in_range &&
                  (req_data.coef_slot == SLOT_W'(k));
      cst_ram #(
         .WIDTH (COEF_W),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (addr),
         .wr_data (req_data.coef_value),
         .rd_en   (req_tready),
         .rd_addr (addr),
         .rd_data (rd_coefs[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_in_range_ff <= in_range;
         s1_last_ff     <= req_tlast;
         s1_offset_ff   <= req_data.offset;
      end
   end

   assign rd_tag.valid    = s1_valid_ff;
   assign rd_tag.in_range = s1_in_range_ff;
   assign rd_tag.last     = s1_last_ff;
   assign rd_tag.offset   = s1_offset_ff;

endmodule

>>> rtl/core/cst_horner.sv
// horner pipeline for value and slope with rounding, saturation and output register
module cst_horner (
   input  logic                           clock,
   input  logic                           reset,
   input  cst_pkg::tag_type               rd_tag,
   input  cst_pkg::coef_set_type          rd_coefs,
   output logic                           adv,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import cst_pkg::*;

   localparam int MUL_W = OFFSET_W + 1;
   localparam int A2_W  = COEF_W + 1;
   localparam int A1_W  = COEF_W + 2;
   localparam int V_W   = COEF_W + 3;
   localparam int B2_W  = COEF_W + 2;
   localparam int B1_W  = COEF_W + 3;
   localparam int S_W   = COEF_W + 4;

   // stage 1 (ram output)
   logic signed [COEF_W-1:0]       c0_1, c1_1, c2_1, c3_1;
   logic signed [MUL_W-1:0]        u1;
   logic signed [B2_W-1:0]         b2;
   logic signed [COEF_W+MUL_W-1:0] pa3_in;
   logic signed [B2_W+MUL_W-1:0]   pb2_in;

   // stage 2
   logic                           v2_ff;
   tag_type                        tag2_ff;
   logic signed [COEF_W+MUL_W-1:0] pa3_ff;
   logic signed [B2_W+MUL_W-1:0]   pb2_ff;
   logic signed [COEF_W-1:0]       c0_2_ff, c1_2_ff, c2_2_ff;
   logic signed [MUL_W-1:0]        u2;
   logic signed [A2_W-1:0]         a2;
   logic signed [B1_W-1:0]         b1;
   logic signed [A2_W+MUL_W-1:0]   pa2_in;
   logic signed [B1_W+MUL_W-1:0]   pb1_in;

   // stage 3
   logic                           v3_ff;
   tag_type                        tag3_ff;
   logic signed [A2_W+MUL_W-1:0]   pa2_ff;
   logic signed [B1_W+MUL_W-1:0]   pb1_ff;
   logic signed [COEF_W-1:0]       c0_3_ff, c1_3_ff;
   logic signed [MUL_W-1:0]        u3;
   logic signed [A1_W-1:0]         a1;
   logic signed [A1_W+MUL_W-1:0]   pa1_in;
   logic signed [S_W-1:0]          s_in;

   // stage 4
   logic                           v4_ff;
   tag_type                        tag4_ff;
   logic signed [A1_W+MUL_W-1:0]   pa1_ff;
   logic signed [S_W-1:0]          s_ff;
   logic signed [COEF_W-1:0]       c0_4_ff;
   logic signed [V_W-1:0]          v;
   sat_type                        v_sat;
   sat_type                        s_sat;

   // output register
   logic                           vo_ff;
   logic [COEF_W-1:0]              value_ff, value_in;
   logic [COEF_W-1:0]              slope_ff, slope_in;
   logic                           sat_ff, sat_in;
   logic                           last_ff;

   logic en_o, en4, en3, en2;

   assign en_o = !vo_ff || rsp_tready;
   assign en4  = !v4_ff || en_o;
   assign en3  = !v3_ff || en4;
   assign en2  = !v2_ff || en3;
   assign adv  = en2;

   assign c0_1   = $signed(rd_coefs[0]);
   assign c1_1   = $signed(rd_coefs[1]);
   assign c2_1   = $signed(rd_coefs[2]);
   assign c3_1   = $signed(rd_coefs[3]);
   assign u1     = $signed({1'b0, rd_tag.offset});
   assign b2     = B2_W'(c3_1) + (B2_W'(c3_1) <<< 1);
   assign pa3_in = c3_1 * u1;
   assign pb2_in = b2 * u1;

   assign u2     = $signed({1'b0, tag2_ff.offset});
   assign a2     = A2_W'(c2_2_ff) + A2_W'(round_q16(PROD_W'(pa3_ff)));
   assign b1     = (B1_W'(c2_2_ff) <<< 1) + B1_W'(round_q16(PROD_W'(pb2_ff)));
   assign pa2_in = a2 * u2;
   assign pb1_in = b1 * u2;

   assign u3     = $signed({1'b0, tag3_ff.offset});
   assign a1     = A1_W'(c1_3_ff) + A1_W'(round_q16(PROD_W'(pa2_ff)));
   assign pa1_in = a1 * u3;
   assign s_in   = S_W'(c1_3_ff) + S_W'(round_q16(PROD_W'(pb1_ff)));

   assign v     = V_W'(c0_4_ff) + V_W'(round_q16(PROD_W'(pa1_ff)));
   assign v_sat = sat_q24(ACC_W'(v));
   assign s_sat = sat_q24(ACC_W'(s_ff));

   always_comb begin
      if (tag4_ff.in_range) begin
         value_in = v_sat.word;
         slope_in = s_sat.word;
         sat_in   = v_sat.clip || s_sat.clip;
      end else begin
         value_in = '0;
         slope_in = '0;
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en2) begin
            v2_ff <= rd_tag.valid;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en_o) begin
            vo_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         tag2_ff <= rd_tag;
         pa3_ff  <= pa3_in;
         pb2_ff  <= pb2_in;
         c0_2_ff <= c0_1;
         c1_2_ff <= c1_1;
         c2_2_ff <= c2_1;
      end
      if (en3) begin
         tag3_ff <= tag2_ff;
         pa2_ff  <= pa2_in;
         pb1_ff  <= pb1_in;
         c0_3_ff <= c0_2_ff;
         c1_3_ff <= c1_2_ff;
      end
      if (en4) begin
         tag4_ff <= tag3_ff;
         pa1_ff  <= pa1_in;
         s_ff    <= s_in;
         c0_4_ff <= c0_3_ff;
      end
      if (en_o) begin
         value_ff <= value_in;
         slope_ff <= slope_in;
         sat_ff   <= sat_in;
         last_ff  <= tag4_ff.last;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {slope_ff, value_ff};
   assign rsp_tuser  = sat_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> rtl/core/cubic_spline_table_eval.sv
// top level of the piecewise cubic spline table evaluator
//
// channel  dir  bits of tdata / tuser / tlast
// req      in   tdata: func_index[1:0] segment[9:2] coef_slot[11:10] coef_value[43:12]
//               offset[59:44] zero[63:60]; tuser: op (0 load, 1 evaluate); tlast: last_point
// rsp      out  tdata: value[31:0] slope[63:32]; tuser: saturated; tlast: last
//
// one item per cycle unless a stalled rsp has filled the pipeline; a load is done in
// the cycle it is accepted and gives no result; an evaluate is read from the rams at its
// accepting edge, then passes three multiply stages and the output register, which raises
// rsp_tvalid; the four coefficient rams are read in parallel
// reset clears the pipeline valid bits only; the table is undefined until loaded
// a stalled rsp holds the pipeline; empty stages still fill, so req stays open until full
module cubic_spline_table_eval #(
   parameter int NUM_FUNCS    = cst_pkg::NUM_FUNCS_DEF,
   parameter int NUM_SEGMENTS = cst_pkg::NUM_SEGMENTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [cst_pkg::REQ_DATA_W-1:0] req_tdata,  // func_index, segment, coef_slot,
                                                      // coef_value, offset
   input  logic                           req_tuser,  // op
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cst_pkg::RSP_DATA_W-1:0] rsp_tdata,  // value, slope
   output logic                           rsp_tuser,  // saturated
   output logic                           rsp_tlast
);
   import cst_pkg::*;

   tag_type      rd_tag;
   coef_set_type rd_coefs;
   logic         adv;

   cst_coef_store #(
      .NUM_FUNCS    (NUM_FUNCS),
      .NUM_SEGMENTS (NUM_SEGMENTS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .adv        (adv),
      .rd_tag     (rd_tag),
      .rd_coefs   (rd_coefs)
   );

   cst_horner u_horner (
      .clock      (clock),
      .reset      (reset),
      .rd_tag     (rd_tag),
      .rd_coefs   (rd_coefs),
      .adv        (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/core/cst_chk.sv
// port-level checks for the cubic spline table evaluator
module cst_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import cst_pkg::*;

   logic [COEF_W-1:0] value;
   logic [COEF_W-1:0] slope;

   assign value = rsp_tdata[COEF_W-1:0];
   assign slope = rsp_tdata[2*COEF_W-1:COEF_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         value == COEF_MAX || value == COEF_MIN || slope == COEF_MAX || slope == COEF_MIN)
      else $error("saturated flag without a clipped result");

   a_no_early_result: assert property (@(posedge clock)
      reset ##1 !reset |-> !rsp_tvalid)
      else $error("result before any item could pass the pipeline");

   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready || !$past(req_tready) || $past(req_tvalid && !req_tready))
      else $error("req blocked with an empty output register");

endmodule

bind cubic_spline_table_eval cst_chk u_cst_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
